// ===== src/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checks a property on every rising edge of clk_i, off while in reset
`define ASSERT_CLK(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("assertion failed");

// checks that a condition never holds
`define ASSERT_NEVER(lbl, cond) \
  `ASSERT_CLK(lbl, !(cond))

`endif

// ===== src/dmsp_pkg.sv =====
`default_nettype none

package dmsp_pkg;

  localparam int GAIN_W  = 20;
  localparam int DATA_W  = 16;
  localparam int ERR_W   = 17;
  localparam int INTEG_W = 11;
  localparam int DER_W   = 18;
  localparam int PROD_W  = 39;
  localparam int RAW_W   = 41;
  localparam int SCL_W   = 52;
  localparam int FILT_W  = 28;
  localparam int DUTY_W  = 15;

  localparam int INTEG_CLAMP = 1000;

  localparam logic [1:0] CFG_KP = 2'd0;
  localparam logic [1:0] CFG_KI = 2'd1;
  localparam logic [1:0] CFG_KD = 2'd2;

  typedef struct packed {
    logic [GAIN_W-1:0] kp;
    logic [GAIN_W-1:0] ki;
    logic [GAIN_W-1:0] kd;
  } gains_t;

  typedef struct packed {
    logic turn;
    logic track;
  } mode_t;

  typedef struct packed {
    logic [DUTY_W-1:0] right_duty;
    logic              right_in2;
    logic              right_in1;
    logic [DUTY_W-1:0] left_duty;
    logic              left_in2;
    logic              left_in1;
  } result_t;

  typedef enum logic [2:0] {
    LANE_IDLE,
    LANE_MUL_P,
    LANE_MUL_I,
    LANE_MUL_D,
    LANE_ACC,
    LANE_SCALE,
    LANE_FILT
  } lane_state_e;

endpackage

`default_nettype wire

// ===== src/dmsp_lane.sv =====
`default_nettype none

module dmsp_lane import dmsp_pkg::*; #(
  parameter int PWM_LIMIT = 1000
) (
  input  wire                      clk_i,
  input  wire                      rst_ni,
  input  wire                      start_i,
  input  gains_t                   gains_i,
  input  wire signed [DATA_W-1:0]  target_i,
  input  wire signed [DATA_W-1:0]  measured_i,
  output logic                     done_o,
  output logic signed [DATA_W-1:0] held_o
);

  localparam logic signed [41:0] Lim = 42'(PWM_LIMIT) <<< 12;

  lane_state_e state_q, state_d;

  logic signed [INTEG_W-1:0] integ_q;
  logic signed [ERR_W-1:0]   prev_q;
  logic signed [FILT_W-1:0]  filt_q;
  logic signed [DATA_W-1:0]  held_q;
  logic signed [ERR_W-1:0]   err_q;
  logic signed [INTEG_W-1:0] acc_q;
  logic signed [DER_W-1:0]   der_q;
  logic signed [PROD_W-1:0]  prod_q;
  logic signed [RAW_W-1:0]   raw_q;
  logic signed [SCL_W-1:0]   scaled_q;

  logic signed [ERR_W-1:0]   err_d;
  logic signed [DER_W-1:0]   sum_i;
  logic signed [INTEG_W-1:0] acc_d;
  logic signed [DER_W-1:0]   der_d;
  logic signed [GAIN_W:0]    mul_a;
  logic signed [DER_W-1:0]   mul_b;
  logic signed [PROD_W-1:0]  prod_d;
  logic signed [SCL_W-1:0]   raw_x;
  logic signed [SCL_W-1:0]   filt_x;
  logic signed [SCL_W-1:0]   mix;
  logic signed [41:0]        f_full;
  logic signed [FILT_W-1:0]  f_lim;
  logic signed [FILT_W-1:0]  f_neg;
  logic signed [DATA_W-1:0]  held_d;

  always_comb begin
    err_d = ERR_W'(target_i) - ERR_W'(measured_i);
    sum_i = DER_W'(integ_q) + DER_W'(err_d);
    if (sum_i > DER_W'(INTEG_CLAMP)) begin
      acc_d = INTEG_W'(INTEG_CLAMP);
    end else if (sum_i < -DER_W'(INTEG_CLAMP)) begin
      acc_d = -INTEG_W'(INTEG_CLAMP);
    end else begin
      acc_d = INTEG_W'(sum_i);
    end
    der_d = DER_W'(err_d) - DER_W'(prev_q);
  end

  // one shared multiplier walks through the three gain products
  always_comb begin
    case (state_q)
      LANE_MUL_I: begin
        mul_a = $signed({1'b0, gains_i.ki});
        mul_b = DER_W'(acc_q);
      end
      LANE_MUL_D: begin
        mul_a = $signed({1'b0, gains_i.kd});
        mul_b = der_q;
      end
      default: begin
        mul_a = $signed({1'b0, gains_i.kp});
        mul_b = DER_W'(err_q);
      end
    endcase
    prod_d = PROD_W'(mul_a) * PROD_W'(mul_b);
  end

  // low-pass: 942*raw and 82*previous as shift-add, floor by arithmetic shift
  always_comb begin
    raw_x  = SCL_W'(raw_q);
    filt_x = SCL_W'(filt_q);
    mix    = (filt_x <<< 6) + (filt_x <<< 4) + (filt_x <<< 1) + scaled_q;
    f_full = 42'(mix >>> 10);
    if (f_full > Lim) begin
      f_lim = FILT_W'(Lim);
    end else if (f_full < -Lim) begin
      f_lim = FILT_W'(-Lim);
    end else begin
      f_lim = FILT_W'(f_full);
    end
    f_neg = -f_lim;
    // truncate toward zero
    if (f_lim >= 0) begin
      held_d = DATA_W'(f_lim >>> 12);
    end else begin
      held_d = -DATA_W'(f_neg >>> 12);
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      LANE_IDLE:  if (start_i) state_d = LANE_MUL_P;
      LANE_MUL_P: state_d = LANE_MUL_I;
      LANE_MUL_I: state_d = LANE_MUL_D;
      LANE_MUL_D: state_d = LANE_ACC;
      LANE_ACC:   state_d = LANE_SCALE;
      LANE_SCALE: state_d = LANE_FILT;
      LANE_FILT:  state_d = LANE_IDLE;
      default:    state_d = LANE_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= LANE_IDLE;
      integ_q <= '0;
      prev_q  <= '0;
      filt_q  <= '0;
      held_q  <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == LANE_IDLE && start_i) begin
        integ_q <= acc_d;
        prev_q  <= err_d;
      end
      if (state_q == LANE_FILT) begin
        filt_q <= f_lim;
        held_q <= held_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      LANE_IDLE: begin
        err_q <= err_d;
        acc_q <= acc_d;
        der_q <= der_d;
      end
      LANE_MUL_P: begin
        prod_q <= prod_d;
        raw_q  <= '0;
      end
      LANE_MUL_I, LANE_MUL_D: begin
        prod_q <= prod_d;
        raw_q  <= raw_q + RAW_W'(prod_q);
      end
      LANE_ACC: raw_q <= raw_q + RAW_W'(prod_q);
      LANE_SCALE: scaled_q <= (raw_x <<< 10) - (raw_x <<< 6) - (raw_x <<< 4) - (raw_x <<< 1);
      default: ;
    endcase
  end

  assign done_o = (state_q == LANE_FILT);
  assign held_o = held_q;

endmodule

`default_nettype wire

// ===== src/dmsp_merge.sv =====
`default_nettype none

module dmsp_merge import dmsp_pkg::*; #(
  parameter int PWM_LIMIT = 1000
) (
  input  mode_t                   mode_i,
  input  wire signed [DATA_W-1:0] target_left_i,
  input  wire signed [DATA_W-1:0] target_right_i,
  input  wire signed [DATA_W-1:0] held_left_i,
  input  wire signed [DATA_W-1:0] held_right_i,
  output result_t                 result_o
);

  localparam logic signed [DATA_W-1:0] Lim = DATA_W'(PWM_LIMIT);

  logic signed [DATA_W-1:0] cmd_l, cmd_r;
  logic [2+DUTY_W-1:0]      drv_l, drv_r;

  function automatic logic signed [DATA_W-1:0] clamp_cmd(input logic signed [DATA_W-1:0] v);
    logic signed [DATA_W-1:0] r;
    if (v > Lim) begin
      r = Lim;
    end else if (v < -Lim) begin
      r = -Lim;
    end else begin
      r = v;
    end
    return r;
  endfunction

  // packs {duty, in2, in1}; zero counts as forward
  function automatic logic [2+DUTY_W-1:0] drive(input logic signed [DATA_W-1:0] v);
    logic signed [DATA_W-1:0] n;
    logic [2+DUTY_W-1:0]      r;
    n = -v;
    if (v >= 0) begin
      r = {DUTY_W'(v), 1'b0, 1'b1};
    end else begin
      r = {DUTY_W'(n), 1'b1, 1'b0};
    end
    return r;
  endfunction

  always_comb begin
    if (mode_i.turn) begin
      cmd_l = clamp_cmd(target_left_i);
      cmd_r = clamp_cmd(target_right_i);
    end else begin
      cmd_l = held_left_i;
      cmd_r = held_right_i;
    end
    drv_l = drive(cmd_l);
    drv_r = drive(cmd_r);
    if (mode_i.turn || mode_i.track) begin
      {result_o.left_duty, result_o.left_in2, result_o.left_in1}    = drv_l;
      {result_o.right_duty, result_o.right_in2, result_o.right_in1} = drv_r;
    end else begin
      // both motors stopped
      result_o.left_in1   = 1'b0;
      result_o.left_in2   = 1'b0;
      result_o.left_duty  = DUTY_W'(PWM_LIMIT);
      result_o.right_in1  = 1'b0;
      result_o.right_in2  = 1'b0;
      result_o.right_duty = DUTY_W'(PWM_LIMIT);
    end
  end

endmodule

`default_nettype wire

// ===== src/dual_motor_speed_pid_drive.sv =====
// Two-wheel speed controller. Each transfer on the slave stream is one control
// tick: targets and measured speeds for both wheels plus track and turn mode
// bits; each tick returns one master transfer with direction bits and duty for
// both wheels. The wheels run in two identical PID lanes side by side, each with
// one shared 21x18 multiplier stepped by a seven-state sequencer, so a tick with
// tracking on is loaded as a result once both lanes have run through the
// sequencer, and the next tick is taken the cycle after the result is loaded; a
// tick without tracking bypasses the lanes and is loaded without waiting on them.
// A result is loaded only once the output register is free or being read, so a
// stalled master side holds the input off. A finished result waits in the output
// register while the next tick is accepted. Gains are unsigned Q8.12; the user
// must write them through the cfg port only while the block is idle, as the block
// itself does not enforce this.
`default_nettype none
`include "assert_macros.svh"

module dual_motor_speed_pid_drive import dmsp_pkg::*; #(
  parameter int PWM_LIMIT = 1000
) (
  input  wire               clk_i,
  input  wire               rst_ni,
  // target_left, target_right, measured_left, measured_right
  input  wire  [63:0]       s_axis_tdata,
  // track_enable, turn_enable
  input  wire  [1:0]        s_axis_tuser,
  input  wire               s_axis_tvalid,
  output logic              s_axis_tready,
  // left_in1, left_in2, left_duty, right_in1, right_in2, right_duty, zero pad
  output logic [39:0]       m_axis_tdata,
  output logic              m_axis_tvalid,
  input  wire               m_axis_tready,
  input  wire               cfg_we_i,
  input  wire  [1:0]        cfg_idx_i,
  input  wire  [GAIN_W-1:0] cfg_data_i
);

  gains_t gains_q;
  logic   busy_q, wait_q, out_valid_q;
  mode_t  mode_q;
  logic signed [DATA_W-1:0] tgt_l_q, tgt_r_q;
  result_t result_q, result_d;

  logic accept, load, start;
  logic done_l, done_r;
  logic signed [DATA_W-1:0] held_l, held_r;

  assign s_axis_tready = ~busy_q;
  assign accept        = s_axis_tvalid & s_axis_tready;
  assign start         = accept & s_axis_tuser[0];
  assign load          = busy_q & ~wait_q & (~out_valid_q | m_axis_tready);

  dmsp_lane #(.PWM_LIMIT(PWM_LIMIT)) u_lane_l (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start),
    .gains_i    (gains_q),
    .target_i   ($signed(s_axis_tdata[15:0])),
    .measured_i ($signed(s_axis_tdata[47:32])),
    .done_o     (done_l),
    .held_o     (held_l)
  );

  dmsp_lane #(.PWM_LIMIT(PWM_LIMIT)) u_lane_r (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start),
    .gains_i    (gains_q),
    .target_i   ($signed(s_axis_tdata[31:16])),
    .measured_i ($signed(s_axis_tdata[63:48])),
    .done_o     (done_r),
    .held_o     (held_r)
  );

  dmsp_merge #(.PWM_LIMIT(PWM_LIMIT)) u_merge (
    .mode_i         (mode_q),
    .target_left_i  (tgt_l_q),
    .target_right_i (tgt_r_q),
    .held_left_i    (held_l),
    .held_right_i   (held_r),
    .result_o       (result_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gains_q.kp  <= GAIN_W'(8806);
      gains_q.ki  <= GAIN_W'(4506);
      gains_q.kd  <= GAIN_W'(4);
      busy_q      <= 1'b0;
      wait_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_KP:  gains_q.kp <= cfg_data_i;
          CFG_KI:  gains_q.ki <= cfg_data_i;
          CFG_KD:  gains_q.kd <= cfg_data_i;
          default: ;
        endcase
      end
      if (load) begin
        busy_q <= 1'b0;
      end else if (accept) begin
        busy_q <= 1'b1;
      end
      if (start) begin
        wait_q <= 1'b1;
      end else if (done_l) begin
        wait_q <= 1'b0;
      end
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      tgt_l_q     <= $signed(s_axis_tdata[15:0]);
      tgt_r_q     <= $signed(s_axis_tdata[31:16]);
      mode_q.track <= s_axis_tuser[0];
      mode_q.turn  <= s_axis_tuser[1];
    end
    if (load) begin
      result_q <= result_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {6'b0, result_q};

  `ASSERT_CLK(a_lanes_in_step, done_l == done_r)
  `ASSERT_CLK(a_done_only_when_waiting, done_l |-> wait_q)
  `ASSERT_CLK(a_idle_stops, load && !mode_q.track && !mode_q.turn |=>
      m_axis_tdata[16:2] == DUTY_W'(PWM_LIMIT) && m_axis_tdata[1:0] == 2'b00)

endmodule

`default_nettype wire

// ===== sim/tb_top.sv =====
`default_nettype none

module tb_top import dmsp_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int DUTY_LIMIT      = 1000;
  localparam logic [1:0] CFG_UNUSED = 2'd3;
  localparam int ITEMS_PER_PHASE = 88;
  localparam int GAIN_PHASES     = 6;
  localparam int HOLDOFF_AT      = 200;
  localparam int HOLDOFF_CYCLES  = 400;
  localparam int STUCK_LIMIT     = 3000;
  localparam int MAX_REPORTS     = 10;

  typedef struct {
    logic signed [DATA_W-1:0] tl;
    logic signed [DATA_W-1:0] tr;
    logic signed [DATA_W-1:0] ml;
    logic signed [DATA_W-1:0] mr;
    logic                     track;
    logic                     turn;
  } speed_tick_t;

  typedef struct {
    speed_tick_t tick;
    bit          fixed;
    result_t     res;
  } tick_row_t;

  logic              clk_i;
  logic              rst_ni;
  logic [63:0]       s_axis_tdata;
  logic [1:0]        s_axis_tuser;
  logic              s_axis_tvalid;
  logic              s_axis_tready;
  logic [39:0]       m_axis_tdata;
  logic              m_axis_tvalid;
  logic              m_axis_tready;
  logic              cfg_we_i;
  logic [1:0]        cfg_idx_i;
  logic [GAIN_W-1:0] cfg_data_i;

  dual_motor_speed_pid_drive #(
    .PWM_LIMIT(DUTY_LIMIT)
  ) i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i)
  );

  // controller model state, per wheel (0 left, 1 right)
  longint gain_kp = 8806;
  longint gain_ki = 4506;
  longint gain_kd = 4;
  int     integ_acc[2];
  int     last_err[2];
  longint filt_q12[2];
  int     held_cmd[2];

  result_t   drive_expected_q[$];
  tick_row_t directed_rows[$];

  int  drive_errors;
  int  results_checked;
  int  ticks_sent;
  int  track_ticks;
  int  turn_ticks;
  int  both_ticks;
  int  idle_ticks;
  int  stuck_cycles;
  bit  send_burst;
  bit  recv_burst;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  function automatic void pid_lane_step(input int w, input int target, input int meas);
    int     err;
    int     acc;
    int     der;
    longint raw;
    longint f;
    longint lim;
    err = target - meas;
    acc = integ_acc[w] + err;
    if (acc > INTEG_CLAMP) acc = INTEG_CLAMP;
    if (acc < -INTEG_CLAMP) acc = -INTEG_CLAMP;
    integ_acc[w] = acc;
    der = err - last_err[w];
    last_err[w] = err;
    raw = gain_kp * err + gain_ki * acc + gain_kd * der;
    // arithmetic shift gives the floor of the division
    f = (82 * filt_q12[w] + 942 * raw) >>> 10;
    lim = longint'(DUTY_LIMIT) * 4096;
    if (f > lim) f = lim;
    if (f < -lim) f = -lim;
    filt_q12[w] = f;
    held_cmd[w] = int'(f / 4096);
  endfunction

  // {duty, in2, in1} for one bridge
  function automatic logic [DUTY_W+1:0] bridge_bits(input int v);
    int c;
    c = v;
    if (c > DUTY_LIMIT) c = DUTY_LIMIT;
    if (c < -DUTY_LIMIT) c = -DUTY_LIMIT;
    if (c >= 0) return {c[DUTY_W-1:0], 1'b0, 1'b1};
    c = -c;
    return {c[DUTY_W-1:0], 1'b1, 1'b0};
  endfunction

  function automatic result_t predict_drive_outputs(input speed_tick_t t);
    result_t r;
    if (t.track) begin
      pid_lane_step(0, t.tl, t.ml);
      pid_lane_step(1, t.tr, t.mr);
    end
    if (t.turn) begin
      r = result_t'({bridge_bits(t.tr), bridge_bits(t.tl)});
    end else if (t.track) begin
      r = result_t'({bridge_bits(held_cmd[1]), bridge_bits(held_cmd[0])});
    end else begin
      r = '0;
      r.left_duty  = DUTY_W'(DUTY_LIMIT);
      r.right_duty = DUTY_W'(DUTY_LIMIT);
    end
    return r;
  endfunction

  function automatic result_t bridge_result(input bit l1, input bit l2, input int ld,
                                            input bit r1, input bit r2, input int rd);
    result_t r;
    r.left_in1   = l1;
    r.left_in2   = l2;
    r.left_duty  = DUTY_W'(ld);
    r.right_in1  = r1;
    r.right_in2  = r2;
    r.right_duty = DUTY_W'(rd);
    return r;
  endfunction

  task automatic add_row(input int tl, input int tr, input int ml, input int mr,
                         input bit track, input bit turn, input bit fixed, input result_t res);
    tick_row_t row;
    row.tick.tl    = tl[DATA_W-1:0];
    row.tick.tr    = tr[DATA_W-1:0];
    row.tick.ml    = ml[DATA_W-1:0];
    row.tick.mr    = mr[DATA_W-1:0];
    row.tick.track = track;
    row.tick.turn  = turn;
    row.fixed      = fixed;
    row.res        = res;
    directed_rows.push_back(row);
  endtask

  function automatic speed_tick_t random_tick();
    speed_tick_t t;
    int          sel;
    int          base;
    sel = $urandom_range(99);
    t.track = (sel < 70);
    t.turn  = (sel >= 55 && sel < 85);
    if ($urandom_range(9) < 7) begin
      // realistic wheel speeds with the measurement close to the target
      base = int'($urandom_range(3000)) - 1500;
      t.tl = base[DATA_W-1:0];
      base = base + int'($urandom_range(400)) - 200;
      t.ml = base[DATA_W-1:0];
      base = int'($urandom_range(3000)) - 1500;
      t.tr = base[DATA_W-1:0];
      base = base + int'($urandom_range(400)) - 200;
      t.mr = base[DATA_W-1:0];
    end else begin
      t.tl = DATA_W'($urandom());
      t.tr = DATA_W'($urandom());
      t.ml = DATA_W'($urandom());
      t.mr = DATA_W'($urandom());
    end
    return t;
  endfunction

  // called at a rising edge; leaves tvalid high after the transfer
  task automatic send_tick(input speed_tick_t t, input bit fixed, input result_t res);
    int      gap;
    result_t predicted;
    gap = send_burst ? 0 : $urandom_range(10);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tdata  <= {t.mr, t.ml, t.tr, t.tl};
    s_axis_tuser  <= {t.turn, t.track};
    s_axis_tvalid <= 1'b1;
    do @(negedge clk_i); while (!s_axis_tready);
    @(posedge clk_i);
    predicted = predict_drive_outputs(t);
    drive_expected_q.push_back(fixed ? res : predicted);
    ticks_sent++;
    if (t.turn && t.track) both_ticks++;
    else if (t.turn) turn_ticks++;
    else if (t.track) track_ticks++;
    else idle_ticks++;
  endtask

  task automatic load_gains(input int kp, input int ki, input int kd);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CFG_KP;
    cfg_data_i <= kp[GAIN_W-1:0];
    @(posedge clk_i);
    cfg_idx_i  <= CFG_KI;
    cfg_data_i <= ki[GAIN_W-1:0];
    @(posedge clk_i);
    cfg_idx_i  <= CFG_KD;
    cfg_data_i <= kd[GAIN_W-1:0];
    @(posedge clk_i);
    // unused index must leave the gains alone
    cfg_idx_i  <= CFG_UNUSED;
    cfg_data_i <= GAIN_W'($urandom());
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    gain_kp = kp & 32'hFFFFF;
    gain_ki = ki & 32'hFFFFF;
    gain_kd = kd & 32'hFFFFF;
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (drive_expected_q.size() != 0) @(posedge clk_i);
    repeat (12) @(posedge clk_i);
  endtask

  // receiver: random stalls, one long hold-off to back up the input side
  initial begin
    int      stall;
    bit      bad;
    result_t exp;
    result_t got;
    while (rst_ni !== 1'b1) @(posedge clk_i);
    forever begin
      if (results_checked % 30 == 0) recv_burst = ($urandom_range(3) == 0);
      if (results_checked == HOLDOFF_AT) stall = HOLDOFF_CYCLES;
      else stall = recv_burst ? 0 : $urandom_range(10);
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(negedge clk_i); while (!m_axis_tvalid);
      got = result_t'(m_axis_tdata[$bits(result_t)-1:0]);
      if (drive_expected_q.size() == 0) begin
        drive_errors++;
        if (drive_errors <= MAX_REPORTS)
          $display("drive result with nothing pending: %h", m_axis_tdata);
      end else begin
        exp = drive_expected_q.pop_front();
        bad = (got.left_in1 !== exp.left_in1) || (got.left_in2 !== exp.left_in2) ||
              (got.left_duty !== exp.left_duty) || (got.right_in1 !== exp.right_in1) ||
              (got.right_in2 !== exp.right_in2) || (got.right_duty !== exp.right_duty) ||
              (m_axis_tdata[39:$bits(result_t)] !== '0);
        if (bad) begin
          drive_errors++;
          if (drive_errors <= MAX_REPORTS)
            $display("result %0d: expected L %b%b/%0d R %b%b/%0d, got L %b%b/%0d R %b%b/%0d pad %h",
                     results_checked, exp.left_in1, exp.left_in2, exp.left_duty,
                     exp.right_in1, exp.right_in2, exp.right_duty,
                     got.left_in1, got.left_in2, got.left_duty,
                     got.right_in1, got.right_in2, got.right_duty,
                     m_axis_tdata[39:$bits(result_t)]);
        end
      end
      results_checked++;
      @(posedge clk_i);
    end
  end

  always @(negedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      stuck_cycles = 0;
    end else begin
      stuck_cycles++;
      if (stuck_cycles >= STUCK_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  initial begin
    speed_tick_t t;
    result_t     idle_res;
    result_t     none;
    int          phase;
    int          n;
    rst_ni        <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= '0;
    s_axis_tvalid <= 1'b0;
    m_axis_tready <= 1'b0;
    cfg_we_i      <= 1'b0;
    cfg_idx_i     <= CFG_KP;
    cfg_data_i    <= '0;
    for (int w = 0; w < 2; w++) begin
      integ_acc[w] = 0;
      last_err[w]  = 0;
      filt_q12[w]  = 0;
      held_cmd[w]  = 0;
    end
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    idle_res = bridge_result(0, 0, DUTY_LIMIT, 0, 0, DUTY_LIMIT);
    none = '0;
    // tl, tr, ml, mr, track, turn
    add_row(0, 0, 0, 0, 0, 0, 1, idle_res);
    add_row(32767, -32768, -32768, 32767, 0, 0, 1, idle_res);
    add_row(32767, -32768, 0, 0, 0, 1, 1, bridge_result(1, 0, 1000, 0, 1, 1000));
    add_row(0, -1, 12345, -12345, 0, 1, 1, bridge_result(1, 0, 0, 0, 1, 1));
    add_row(1000, -1000, 0, 0, 0, 1, 1, bridge_result(1, 0, 1000, 0, 1, 1000));
    add_row(1001, -1001, 0, 0, 0, 1, 1, bridge_result(1, 0, 1000, 0, 1, 1000));
    add_row(999, -999, 0, 0, 0, 1, 1, bridge_result(1, 0, 999, 0, 1, 999));
    add_row(0, 0, 0, 0, 1, 0, 1, bridge_result(1, 0, 0, 1, 0, 0));
    // full-scale error saturates the filter
    add_row(32767, -32768, -32768, 32767, 1, 0, 1, bridge_result(1, 0, 1000, 0, 1, 1000));
    add_row(32767, -32768, -32768, 32767, 1, 0, 1, bridge_result(1, 0, 1000, 0, 1, 1000));
    // both modes: turn output wins while the loop keeps running
    add_row(5, -7, -32768, 32767, 1, 1, 1, bridge_result(1, 0, 5, 0, 1, 7));
    add_row(-32768, 32767, 0, 0, 1, 1, 1, bridge_result(0, 1, 1000, 1, 0, 1000));
    add_row(100, -100, 100, -100, 1, 0, 0, none);
    add_row(200, -200, 150, -150, 1, 0, 0, none);
    add_row(-300, 300, -250, 250, 1, 0, 0, none);
    add_row(0, 0, 1, -1, 1, 0, 0, none);
    add_row(-32768, -32768, 32767, 32767, 1, 0, 0, none);
    add_row(16384, -16384, 16383, -16385, 1, 0, 0, none);
    // loop state must survive an idle tick
    add_row(0, 0, 0, 0, 0, 0, 1, idle_res);
    add_row(0, 0, 0, 0, 1, 0, 0, none);
    add_row(21845, -21846, 0, 0, 0, 1, 1, bridge_result(1, 0, 1000, 0, 1, 1000));
    add_row(21845, -21846, -21846, 21845, 1, 0, 0, none);

    send_burst = 0;
    foreach (directed_rows[i])
      send_tick(directed_rows[i].tick, directed_rows[i].fixed, directed_rows[i].res);

    for (phase = 0; phase < GAIN_PHASES; phase++) begin
      if (phase > 0) begin
        wait_drained();
        case (phase)
          1: load_gains(32'hFFFFF, 32'hFFFFF, 32'hFFFFF);
          2: load_gains(0, 0, 0);
          3: load_gains($urandom_range(1 << 14), $urandom_range(1 << 12),
                        $urandom_range(1 << 12));
          4: load_gains($urandom_range(32'hFFFFF), $urandom_range(32'hFFFFF),
                        $urandom_range(32'hFFFFF));
          default: load_gains(1, 0, 32'hFFFFF);
        endcase
      end
      for (n = 0; n < ITEMS_PER_PHASE; n++) begin
        if (n % 40 == 0) send_burst = ($urandom_range(3) == 0);
        t = random_tick();
        send_tick(t, 0, none);
      end
    end

    wait_drained();
    repeat (20) @(posedge clk_i);
    $display("sent %0d ticks over %0d gain settings: %0d track, %0d turn, %0d both, %0d idle",
             ticks_sent, GAIN_PHASES, track_ticks, turn_ticks, both_ticks, idle_ticks);
    $display("checked %0d drive results, %0d errors", results_checked, drive_errors);
    if (drive_errors == 0 && drive_expected_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== sim.f =====
+incdir+src
src/dmsp_pkg.sv
src/dmsp_lane.sv
src/dmsp_merge.sv
src/dual_motor_speed_pid_drive.sv
sim/tb_top.sv
